### hw/rtl/bra_pkg.sv
`default_nettype none

package bra_pkg;

    localparam int unsigned APB_DATA_BITS = 32;
    localparam int unsigned ADDR_BITS     = 3;

    localparam logic [0:0]  REG_MAX_DEN   = 1'b0;
    localparam logic [31:0] MAXDEN_RESET  = 32'd65535;

    typedef enum logic [11:0] {
        ST_IDLE  = 12'b0000_0000_0001,
        ST_DIV   = 12'b0000_0000_0010,
        ST_MULP  = 12'b0000_0000_0100,
        ST_MULQ  = 12'b0000_0000_1000,
        ST_STEP  = 12'b0000_0001_0000,
        ST_FIN   = 12'b0000_0010_0000,
        ST_ADM   = 12'b0000_0100_0000,
        ST_CMP   = 12'b0000_1000_0000,
        ST_FITW  = 12'b0001_0000_0000,
        ST_FMULP = 12'b0010_0000_0000,
        ST_FMULQ = 12'b0100_0000_0000,
        ST_FOUT  = 12'b1000_0000_0000
    } state_t;

endpackage

`default_nettype wire

### hw/rtl/bra_div.sv
`default_nettype none

module bra_div #(
    parameter int unsigned W = 32
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         start,
    input  wire logic [W-1:0] dividend,
    input  wire logic [W-1:0] divisor,
    output logic              done,
    output logic [W-1:0]      quotient,
    output logic [W-1:0]      remainder
);

    localparam int unsigned CW = $clog2(W);

    logic          run_reg;
    logic          run_next;
    logic          done_reg;
    logic          done_next;
    logic [CW-1:0] cnt_reg;
    logic [CW-1:0] cnt_next;
    logic [W-1:0]  quo_reg;
    logic [W-1:0]  quo_next;
    logic [W-1:0]  rem_reg;
    logic [W-1:0]  rem_next;
    logic [W-1:0]  dvs_reg;
    logic [W-1:0]  dvs_next;

    logic [W:0]    shifted;
    logic [W:0]    diff;
    logic          ge;

    assign shifted = {rem_reg, quo_reg[W-1]};
    assign ge      = (shifted >= {1'b0, dvs_reg});
    assign diff    = shifted - {1'b0, dvs_reg};

    always_comb
    begin
        run_next  = run_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        if (start)
        begin
            run_next = 1'b1;
            cnt_next = CW'(W - 1);
            quo_next = dividend;
            rem_next = '0;
            dvs_next = divisor;
        end
        else if (run_reg)
        begin
            // one quotient bit per cycle
            quo_next = {quo_reg[W-2:0], ge};
            rem_next = ge ? diff[W-1:0] : shifted[W-1:0];
            cnt_next = cnt_reg - CW'(1);
            if (cnt_reg == '0)
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

`default_nettype wire

### hw/rtl/bra_cfg.sv
`default_nettype none

module bra_cfg #(
    parameter int unsigned W = 32
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                psel,
    input  wire logic                                penable,
    input  wire logic                                pwrite,
    input  wire logic [bra_pkg::ADDR_BITS-1:0]       paddr,
    input  wire logic [bra_pkg::APB_DATA_BITS-1:0]   pwdata,
    output logic [bra_pkg::APB_DATA_BITS-1:0]        prdata,
    output logic                                     pready,
    output logic [W-1:0]                             max_den
);

    logic [W-1:0] max_den_reg;
    logic [W-1:0] max_den_next;
    logic         hit;

    assign hit = (paddr[bra_pkg::ADDR_BITS-1:2] == bra_pkg::REG_MAX_DEN);

    always_comb
    begin
        max_den_next = max_den_reg;
        if (psel && penable && pwrite && hit)
        begin
            max_den_next = pwdata[W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_den_reg <= W'(bra_pkg::MAXDEN_RESET);
        end
        else
        begin
            max_den_reg <= max_den_next;
        end
    end

    assign prdata  = hit ? bra_pkg::APB_DATA_BITS'(max_den_reg) : '0;
    assign pready  = 1'b1;
    assign max_den = max_den_reg;

endmodule

`default_nettype wire

### hw/rtl/bounded_rational_approximator_unit.sv
// Best rational approximation p/q of numerator/denominator with q <= max_denominator.
// Input: pulse start with numerator and denominator while busy is low; the beat is
// taken at that edge and busy rises right after it, except for a zero denominator.
// Output: done is high for exactly one cycle with approx_numerator, approx_denominator
// and bad_input; the receiver cannot stall, so the beat must be captured then.
// busy falls in the cycle done is high, so the next beat may start there.
// Each Euclid step is bounded by the shared one-bit-per-cycle divider plus two passes
// through the shared multiplier; a 32-bit input needs up to about 47 such steps.
// A zero denominator answers 0/0 with bad_input in the cycle right after acceptance,
// and busy stays low.
// Items are processed one at a time; nothing is kept between them.
// Configuration: APB register max_denominator at byte address 0 (0 counts as 1),
// reset to 65535; write it only while busy is low.
// Reset: rst_n clears the sequencer, the divider and the register asynchronously.
`default_nettype none

module bounded_rational_approximator_unit #(
    parameter int unsigned WORD_BITS = 32
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               start,
    output logic                                    busy,
    input  wire logic [WORD_BITS-1:0]               numerator,
    input  wire logic [WORD_BITS-1:0]               denominator,
    output logic                                    done,
    output logic [WORD_BITS-1:0]                    approx_numerator,
    output logic [WORD_BITS-1:0]                    approx_denominator,
    output logic                                    bad_input,
    input  wire logic                               psel,
    input  wire logic                               penable,
    input  wire logic                               pwrite,
    input  wire logic [bra_pkg::ADDR_BITS-1:0]      paddr,
    input  wire logic [bra_pkg::APB_DATA_BITS-1:0]  pwdata,
    output logic [bra_pkg::APB_DATA_BITS-1:0]       prdata,
    output logic                                    pready
);

    localparam int unsigned W  = WORD_BITS;
    localparam int unsigned PW = 2 * WORD_BITS;

    bra_pkg::state_t state_reg;
    bra_pkg::state_t state_next;

    logic [W-1:0]  max_den;

    logic          done_reg;
    logic          done_next;
    logic          first_reg;
    logic          first_next;
    logic          gt_reg;
    logic          gt_next;
    logic          bad_reg;
    logic          bad_next;

    logic [W-1:0]  p0_reg;
    logic [W-1:0]  p0_next;
    logic [W-1:0]  p1_reg;
    logic [W-1:0]  p1_next;
    logic [W-1:0]  p2_reg;
    logic [W-1:0]  p2_next;
    logic [W-1:0]  q0_reg;
    logic [W-1:0]  q0_next;
    logic [W-1:0]  q1_reg;
    logic [W-1:0]  q1_next;
    logic [W-1:0]  q2_reg;
    logic [W-1:0]  q2_next;
    logic [W-1:0]  a_reg;
    logic [W-1:0]  a_next;
    logic [W-1:0]  r_reg;
    logic [W-1:0]  r_next;
    logic [W-1:0]  rprev_reg;
    logic [W-1:0]  rprev_next;
    logic [W-1:0]  y_reg;
    logic [W-1:0]  y_next;
    logic [W-1:0]  lim_reg;
    logic [W-1:0]  lim_next;
    logic [W-1:0]  fit_reg;
    logic [W-1:0]  fit_next;
    logic [W-1:0]  num_reg;
    logic [W-1:0]  num_next;
    logic [W-1:0]  den_reg;
    logic [W-1:0]  den_next;
    logic [PW-1:0] prod_reg;
    logic [PW-1:0] prod_next;
    logic [PW-1:0] prod_a_reg;
    logic [PW-1:0] prod_a_next;

    logic [W-1:0]  mul_a;
    logic [W-1:0]  mul_b;
    logic [W-1:0]  q2_sum;
    logic [W-1:0]  half;

    logic          div_start;
    logic [W-1:0]  div_dividend;
    logic [W-1:0]  div_divisor;
    logic          div_done;
    logic [W-1:0]  div_quot;
    logic [W-1:0]  div_rem;

    bra_cfg #(
        .W (W)
    ) u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .max_den (max_den)
    );

    bra_div #(
        .W (W)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (div_dividend),
        .divisor   (div_divisor),
        .done      (div_done),
        .quotient  (div_quot),
        .remainder (div_rem)
    );

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        unique case (state_reg)
            bra_pkg::ST_MULP:
            begin
                mul_a = p1_reg;
                mul_b = a_reg;
            end
            bra_pkg::ST_MULQ:
            begin
                mul_a = q1_reg;
                mul_b = a_reg;
            end
            bra_pkg::ST_FIN:
            begin
                mul_a = q0_reg;
                mul_b = rprev_reg;
            end
            bra_pkg::ST_ADM:
            begin
                mul_a = r_reg;
                mul_b = q1_reg;
            end
            bra_pkg::ST_FMULP:
            begin
                mul_a = p1_reg;
                mul_b = fit_reg;
            end
            bra_pkg::ST_FMULQ:
            begin
                mul_a = q1_reg;
                mul_b = fit_reg;
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign prod_next = PW'(mul_a) * PW'(mul_b);
    assign q2_sum    = q0_reg + prod_reg[W-1:0];
    assign half      = {1'b0, a_reg[W-1:1]} + ((!a_reg[0] && gt_reg) ? W'(0) : W'(1));

    always_comb
    begin
        state_next   = state_reg;
        done_next    = 1'b0;
        first_next   = first_reg;
        gt_next      = gt_reg;
        bad_next     = bad_reg;
        p0_next      = p0_reg;
        p1_next      = p1_reg;
        p2_next      = p2_reg;
        q0_next      = q0_reg;
        q1_next      = q1_reg;
        q2_next      = q2_reg;
        a_next       = a_reg;
        r_next       = r_reg;
        rprev_next   = rprev_reg;
        y_next       = y_reg;
        lim_next     = lim_reg;
        fit_next     = fit_reg;
        num_next     = num_reg;
        den_next     = den_reg;
        prod_a_next  = prod_a_reg;
        div_start    = 1'b0;
        div_dividend = '0;
        div_divisor  = '0;

        unique case (state_reg)
            bra_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    if (denominator == '0)
                    begin
                        num_next  = '0;
                        den_next  = '0;
                        bad_next  = 1'b1;
                        done_next = 1'b1;
                    end
                    else
                    begin
                        p0_next      = '0;
                        p1_next      = W'(1);
                        q0_next      = W'(1);
                        q1_next      = '0;
                        rprev_next   = '0;
                        first_next   = 1'b1;
                        y_next       = denominator;
                        lim_next     = (max_den == '0) ? W'(1) : max_den;
                        div_start    = 1'b1;
                        div_dividend = numerator;
                        div_divisor  = denominator;
                        state_next   = bra_pkg::ST_DIV;
                    end
                end
            end
            bra_pkg::ST_DIV:
            begin
                if (div_done)
                begin
                    a_next     = div_quot;
                    r_next     = div_rem;
                    state_next = bra_pkg::ST_MULP;
                end
            end
            bra_pkg::ST_MULP:
            begin
                state_next = bra_pkg::ST_MULQ;
            end
            bra_pkg::ST_MULQ:
            begin
                p2_next    = p0_reg + prod_reg[W-1:0];
                state_next = bra_pkg::ST_STEP;
            end
            bra_pkg::ST_STEP:
            begin
                q2_next = q2_sum;
                if ((r_reg == '0) || (!first_reg && (q2_sum >= lim_reg)))
                begin
                    state_next = bra_pkg::ST_FIN;
                end
                else
                begin
                    // advance to the next convergent
                    first_next   = 1'b0;
                    p0_next      = p1_reg;
                    p1_next      = p2_reg;
                    q0_next      = q1_reg;
                    q1_next      = q2_sum;
                    rprev_next   = r_reg;
                    y_next       = r_reg;
                    div_start    = 1'b1;
                    div_dividend = y_reg;
                    div_divisor  = r_reg;
                    state_next   = bra_pkg::ST_DIV;
                end
            end
            bra_pkg::ST_FIN:
            begin
                if (q2_reg <= lim_reg)
                begin
                    num_next   = p2_reg;
                    den_next   = q2_reg;
                    bad_next   = 1'b0;
                    done_next  = 1'b1;
                    state_next = bra_pkg::ST_IDLE;
                end
                else
                begin
                    state_next = bra_pkg::ST_ADM;
                end
            end
            bra_pkg::ST_ADM:
            begin
                prod_a_next = prod_reg;
                state_next  = bra_pkg::ST_CMP;
            end
            bra_pkg::ST_CMP:
            begin
                gt_next      = (prod_a_reg > prod_reg);
                div_start    = 1'b1;
                div_dividend = lim_reg - q0_reg;
                div_divisor  = q1_reg;
                state_next   = bra_pkg::ST_FITW;
            end
            bra_pkg::ST_FITW:
            begin
                if (div_done)
                begin
                    fit_next = div_quot;
                    if (div_quot < half)
                    begin
                        num_next   = p1_reg;
                        den_next   = q1_reg;
                        bad_next   = 1'b0;
                        done_next  = 1'b1;
                        state_next = bra_pkg::ST_IDLE;
                    end
                    else
                    begin
                        state_next = bra_pkg::ST_FMULP;
                    end
                end
            end
            bra_pkg::ST_FMULP:
            begin
                state_next = bra_pkg::ST_FMULQ;
            end
            bra_pkg::ST_FMULQ:
            begin
                num_next   = p0_reg + prod_reg[W-1:0];
                state_next = bra_pkg::ST_FOUT;
            end
            bra_pkg::ST_FOUT:
            begin
                den_next   = q0_reg + prod_reg[W-1:0];
                bad_next   = 1'b0;
                done_next  = 1'b1;
                state_next = bra_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = bra_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= bra_pkg::ST_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        first_reg  <= first_next;
        gt_reg     <= gt_next;
        bad_reg    <= bad_next;
        p0_reg     <= p0_next;
        p1_reg     <= p1_next;
        p2_reg     <= p2_next;
        q0_reg     <= q0_next;
        q1_reg     <= q1_next;
        q2_reg     <= q2_next;
        a_reg      <= a_next;
        r_reg      <= r_next;
        rprev_reg  <= rprev_next;
        y_reg      <= y_next;
        lim_reg    <= lim_next;
        fit_reg    <= fit_next;
        num_reg    <= num_next;
        den_reg    <= den_next;
        prod_reg   <= prod_next;
        prod_a_reg <= prod_a_next;
    end

    assign busy               = (state_reg != bra_pkg::ST_IDLE);
    assign done               = done_reg;
    assign approx_numerator   = num_reg;
    assign approx_denominator = den_reg;
    assign bad_input          = bad_reg;

endmodule

`default_nettype wire

### sim/bounded_rational_approximator_unit_tb.sv
`default_nettype none

module bounded_rational_approximator_unit_tb;

    typedef struct packed {
        logic [31:0] num;
        logic [31:0] den;
    } fraction_t;

    typedef struct packed {
        logic [31:0] num;
        logic [31:0] den;
        logic        bad;
    } approx_t;

    localparam logic [bra_pkg::ADDR_BITS-1:0] MAXDEN_ADDR = {bra_pkg::REG_MAX_DEN, 2'b00};
    localparam logic [bra_pkg::ADDR_BITS-1:0] SPARE_ADDR  = 3'd4;

    logic                              clk         = 1'b0;
    logic                              rst_n       = 1'b0;
    logic                              start       = 1'b0;
    logic [31:0]                       numerator   = '0;
    logic [31:0]                       denominator = '0;
    logic                              psel        = 1'b0;
    logic                              penable     = 1'b0;
    logic                              pwrite      = 1'b0;
    logic [bra_pkg::ADDR_BITS-1:0]     paddr       = '0;
    logic [bra_pkg::APB_DATA_BITS-1:0] pwdata      = '0;
    logic                              busy;
    logic                              done;
    logic [31:0]                       approx_numerator;
    logic [31:0]                       approx_denominator;
    logic                              bad_input;
    logic [bra_pkg::APB_DATA_BITS-1:0] prdata;
    logic                              pready;

    fraction_t   pending_fractions[$];
    approx_t     awaited_approx[$];
    logic [31:0] max_den_copy = bra_pkg::MAXDEN_RESET;
    int          mismatch_count = 0;
    int          beats_sent = 0;
    bit          draining = 1'b0;
    bit          offer;

    bounded_rational_approximator_unit dut (
        .clk                (clk),
        .rst_n              (rst_n),
        .start              (start),
        .busy               (busy),
        .numerator          (numerator),
        .denominator        (denominator),
        .done               (done),
        .approx_numerator   (approx_numerator),
        .approx_denominator (approx_denominator),
        .bad_input          (bad_input),
        .psel               (psel),
        .penable            (penable),
        .pwrite             (pwrite),
        .paddr              (paddr),
        .pwdata             (pwdata),
        .prdata             (prdata),
        .pready             (pready)
    );

    always #10 clk = ~clk;

    function automatic approx_t best_fraction(input logic [31:0] num, input logic [31:0] den,
                                              input logic [31:0] cap);
        bit [63:0] x, y, lim, p0, p1, p2, q0, q1, q2, a, r, rprev, half, fit, rn, rd;
        bit        first;
        bit        going;
        approx_t   res;
        res = '0;
        if (den == 0)
        begin
            res.bad = 1'b1;
            return res;
        end
        lim = (cap == 0) ? 64'd1 : 64'(cap);
        x = 64'(num);
        y = 64'(den);
        p0 = 0; p1 = 1; q0 = 1; q1 = 0;
        a = 0; r = 0; p2 = 0; q2 = 0; rprev = 0;
        first = 1'b1;
        going = 1'b1;
        while (going)
        begin
            a  = x / y;
            r  = x % y;
            p2 = p0 + p1 * a;
            q2 = q0 + q1 * a;
            if (r == 0 || (!first && q2 >= lim))
                going = 1'b0;
            else
            begin
                first = 1'b0;
                p0 = p1; p1 = p2;
                q0 = q1; q1 = q2;
                x = y;
                y = r;
                rprev = r;
            end
        end
        if (q2 <= lim)
        begin
            rn = p2;
            rd = q2;
        end
        else
        begin
            fit = (q1 != 0) ? (lim - q0) / q1 : 64'd0;
            if (a[0] == 1'b0 && q0 * rprev > r * q1)
                half = a / 2;
            else
                half = a / 2 + 1;
            if (fit < half)
            begin
                rn = p1;
                rd = q1;
            end
            else
            begin
                rn = p0 + p1 * fit;
                rd = q0 + q1 * fit;
            end
        end
        res.num = rn[31:0];
        res.den = rd[31:0];
        return res;
    endfunction

    task automatic note_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
        $display("MISMATCH %s: got %0d, expected %0d", what, got, want);
        mismatch_count++;
    endtask

    // hold the head item on the bus until the beat is taken
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start <= 1'b0;
        end
        else
        begin
            if (start && !busy)
            begin
                awaited_approx.push_back(best_fraction(numerator, denominator, max_den_copy));
                void'(pending_fractions.pop_front());
                beats_sent++;
                if (beats_sent % 37 == 0)
                    draining = 1'b1;
            end
            if (draining && awaited_approx.size() == 0)
                draining = 1'b0;
            offer = pending_fractions.size() != 0 && !draining &&
                    ((beats_sent >= 120 && beats_sent < 200) || $urandom_range(0, 99) >= 26);
            start <= offer;
            if (pending_fractions.size() != 0)
            begin
                numerator   <= pending_fractions[0].num;
                denominator <= pending_fractions[0].den;
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (awaited_approx.size() == 0)
                note_mismatch("result with nothing awaited", approx_numerator, 0);
            else
            begin
                if (approx_numerator !== awaited_approx[0].num)
                    note_mismatch("approx_numerator", approx_numerator, awaited_approx[0].num);
                if (approx_denominator !== awaited_approx[0].den)
                    note_mismatch("approx_denominator", approx_denominator,
                                  awaited_approx[0].den);
                if (bad_input !== awaited_approx[0].bad)
                    note_mismatch("bad_input", 32'(bad_input), 32'(awaited_approx[0].bad));
                void'(awaited_approx.pop_front());
            end
        end
    end

    task automatic apb_write(input logic [bra_pkg::ADDR_BITS-1:0] addr,
                             input logic [bra_pkg::APB_DATA_BITS-1:0] data);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (addr == MAXDEN_ADDR)
            max_den_copy = data;
    endtask

    task automatic wait_idle();
        while (pending_fractions.size() != 0 || start || busy || awaited_approx.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic push_fraction(input logic [31:0] num, input logic [31:0] den);
        fraction_t f;
        f.num = num;
        f.den = den;
        pending_fractions.push_back(f);
    endtask

    task automatic run_random(input int count);
        logic [31:0] num;
        logic [31:0] den;
        for (int i = 0; i < count; i++)
        begin
            case ($urandom_range(0, 9))
                0: begin num = $urandom; den = '0; end
                1: begin num = '0; den = $urandom; end
                2, 3: begin num = $urandom; den = $urandom; end
                4: begin num = $urandom_range(0, 1000); den = $urandom_range(1, 1000); end
                5: begin den = $urandom; num = $urandom_range(0, den); end
                6: begin num = $urandom; den = ($urandom >> $urandom_range(0, 31)) | 32'd1; end
                7: begin num = $urandom >> $urandom_range(0, 31); den = $urandom | 32'd1; end
                8:
                begin
                    den = $urandom_range(1, 100000);
                    num = den * $urandom_range(1, 1000) + $urandom_range(0, 3);
                end
                default: begin num = $urandom; den = num; end
            endcase
            push_fraction(num, den);
        end
        wait_idle();
    endtask

    task automatic push_hard_cases();
        push_fraction(32'd2971215073, 32'd1836311903);
        push_fraction(32'd3141592653, 32'd1000000000);
        push_fraction(32'd0, 32'd5);
        push_fraction(32'd9, 32'd0);
    endtask

    initial
    begin
        logic [31:0] cap;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        push_fraction(32'd0, 32'd0);
        push_fraction(32'hFFFF_FFFF, 32'd0);
        push_fraction(32'd0, 32'd1);
        push_fraction(32'd0, 32'hFFFF_FFFF);
        push_fraction(32'd1, 32'd1);
        push_fraction(32'hFFFF_FFFF, 32'd1);
        push_fraction(32'd1, 32'hFFFF_FFFF);
        push_fraction(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        push_fraction(32'hFFFF_FFFE, 32'hFFFF_FFFF);
        push_fraction(32'hFFFF_FFFF, 32'hFFFF_FFFE);
        push_fraction(32'd1836311903, 32'd2971215073);
        push_fraction(32'h8000_0000, 32'h7FFF_FFFF);
        push_fraction(32'd22, 32'd7);
        push_fraction(32'd1, 32'd65536);
        push_fraction(32'd65537, 32'd65536);
        push_fraction(32'd65536, 32'd65535);
        push_fraction(32'd100, 32'd131071);
        push_fraction(32'd1, 32'd2);
        push_fraction(32'd1, 32'd3);
        push_hard_cases();
        run_random(60);

        apb_write(MAXDEN_ADDR, 32'd1);
        push_hard_cases();
        run_random(40);

        apb_write(MAXDEN_ADDR, 32'd0);
        push_hard_cases();
        run_random(30);

        apb_write(MAXDEN_ADDR, 32'hFFFF_FFFF);
        push_hard_cases();
        run_random(50);

        apb_write(SPARE_ADDR, 32'd3);
        push_hard_cases();
        run_random(10);

        for (int k = 0; k < 5; k++)
        begin
            case (k % 3)
                0: cap = $urandom_range(1, 16);
                1: cap = $urandom_range(1, 65535);
                default: cap = $urandom;
            endcase
            apb_write(MAXDEN_ADDR, cap);
            push_hard_cases();
            run_random(24);
        end

        wait_idle();
        repeat (2000) @(posedge clk);
        if (awaited_approx.size() != 0)
            note_mismatch("results never arrived", 0, awaited_approx.size());
        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    initial
    begin
        #64000000;
        $display("Mismatches found");
        $finish;
    end

endmodule

`default_nettype wire
